[hw/rtl/blru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blru_pkg
// Shared types and constants of the LRU buffer manager.
// ----------------------------------------------------------------------------
package blru_pkg;

  localparam int SLOTS        = 64;
  localparam int SLOT_W       = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int SLOT_FIELD_W = 6;
  localparam int CMP_W        = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
  localparam int DEV_W        = 2;
  localparam int BLK_W        = 32;
  localparam int CNT_W        = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    FN_GET  = 2'd0,
    FN_REL  = 2'd1,
    FN_MARK = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFREE   = 2'd1,
    ST_UNREF    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SEL,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_id;
    logic [BLK_W-1:0]  blk;
    logic [DEV_W-1:0]  dev;
    logic              assigned;
    logic              valid;
    logic [CNT_W-1:0]  cnt;
  } entry_t;

  typedef struct packed {
    logic [DEV_W-1:0]        dev;
    logic [BLK_W-1:0]        blk;
    logic [SLOT_FIELD_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic capture;
    logic load_nbr;
    logic load_new;
  } cell_ctl_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic id;
  } cell_flags_t;

endpackage

[hw/rtl/blru_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blru_ifs
// Request and result channels of the LRU buffer manager.
// ----------------------------------------------------------------------------
interface blru_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] device;
  logic [31:0] block_address;
  logic [5:0] slot;

  modport source (output valid, func, device, block_address, slot, input ready);
  modport sink   (input valid, func, device, block_address, slot, output ready);
endinterface

interface blru_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] result_slot;
  logic       hit;
  logic       needs_read;
  logic [1:0] status;

  modport source (output valid, result_slot, hit, needs_read, status, input ready);
  modport sink   (input valid, result_slot, hit, needs_read, status, output ready);
endinterface

[hw/rtl/blru_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blru_cell
// One recency position: holds a slot entry, compares it, shifts toward older.
// ----------------------------------------------------------------------------
module blru_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [blru_pkg::SLOT_W-1:0] rst_id,
  input  blru_pkg::cell_ctl_t        ctl,
  input  blru_pkg::req_t             req,
  input  blru_pkg::entry_t           nbr_in,
  input  blru_pkg::entry_t           new_in,
  output blru_pkg::entry_t           entry_o,
  output blru_pkg::cell_flags_t      flags_o
);
  import blru_pkg::*;

  entry_t      entry_r;
  entry_t      entry_nxt;
  cell_flags_t flags_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_new) begin
      entry_nxt = new_in;
    end else if (ctl.load_nbr) begin
      entry_nxt = nbr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.slot_id  <= rst_id;
      entry_r.blk      <= '0;
      entry_r.dev      <= '0;
      entry_r.assigned <= 1'b0;
      entry_r.valid    <= 1'b0;
      entry_r.cnt      <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      flags_r.hit  <= entry_r.assigned && (entry_r.dev == req.dev) &&
                      (entry_r.blk == req.blk);
      flags_r.free <= (entry_r.cnt == '0);
      flags_r.id   <= (CMP_W'(entry_r.slot_id) == CMP_W'(req.slot));
    end
  end

  assign entry_o = entry_r;
  assign flags_o = flags_r;

endmodule

[hw/rtl/block_buffer_lru_manager_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_lru_manager_core
// Fully associative buffer slot manager with LRU order and reference counts.
// ----------------------------------------------------------------------------
// channel | dir | beat
// in_ch   | in  | func, device, block_address, slot
// out_ch  | out | result_slot, hit, needs_read, status
//
// Each beat passes through capture, parallel compare in every cell,
// priority select over the chain, then update and shift of the cell chain.
// A new beat is taken while an earlier result still waits on out_ch; the
// update step holds until the output register is free.
// Reset is synchronous; cell i holds slot i afterwards, all counts zero.
module block_buffer_lru_manager_core (
  input  logic      clk,
  input  logic      rst_n,
  blru_in_if.sink   in_ch,
  blru_out_if.source out_ch
);
  import blru_pkg::*;

  state_t      state_r, state_nxt;
  logic [1:0]  func_r;
  req_t        req_r;
  entry_t      entries [SLOTS+1];
  cell_flags_t flags [SLOTS];
  cell_ctl_t   ctls [SLOTS];
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic        found_r, found_nxt;
  logic        hitsel_r, hitsel_nxt;
  logic        out_valid_r;
  logic [5:0]  res_slot_r, res_slot_nxt;
  logic        res_hit_r, res_hit_nxt;
  logic        res_nr_r, res_nr_nxt;
  status_t     res_st_r, res_st_nxt;
  logic        accept, capture, apply_go, out_free;
  logic        move, upd;
  entry_t      cur, new_entry;
  logic [SLOTS-1:0] hit_v, free_v, id_v, sel_v;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MATCH;
      S_MATCH: state_nxt = S_SEL;
      S_SEL:   state_nxt = S_APPLY;
      S_APPLY: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    capture     = 1'b0;
    apply_go    = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ch.ready = 1'b1;
      S_MATCH: capture = 1'b1;
      S_SEL:   ;
      S_APPLY: apply_go = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r      <= in_ch.func;
      req_r.dev   <= in_ch.device;
      req_r.blk   <= in_ch.block_address;
      req_r.slot  <= in_ch.slot;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      assign hit_v[gi]  = flags[gi].hit;
      assign free_v[gi] = flags[gi].free;
      assign id_v[gi]   = flags[gi].id;
      assign ctls[gi].capture  = capture;
      assign ctls[gi].load_nbr = move && (gi != SLOTS - 1) &&
                                 (SLOT_W'(gi) >= pos_r);
      assign ctls[gi].load_new = (move && (gi == SLOTS - 1)) ||
                                 (upd && (SLOT_W'(gi) == pos_r));
      blru_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .rst_id  (SLOT_W'(gi)),
        .ctl     (ctls[gi]),
        .req     (req_r),
        .nbr_in  (entries[gi+1]),
        .new_in  (new_entry),
        .entry_o (entries[gi]),
        .flags_o (flags[gi])
      );
    end
  endgenerate

  assign entries[SLOTS] = new_entry;

  // pick the oldest matching position
  always_comb begin
    hitsel_nxt = hitsel_r;
    if (func_r == FN_GET) begin
      hitsel_nxt = |hit_v;
      sel_v      = (|hit_v) ? hit_v : free_v;
    end else begin
      sel_v = id_v;
    end
    pos_nxt   = '0;
    found_nxt = |sel_v;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (sel_v[i]) pos_nxt = SLOT_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SEL) begin
      pos_r    <= pos_nxt;
      found_r  <= found_nxt;
      hitsel_r <= hitsel_nxt;
    end
  end

  assign cur = entries[pos_r];

  always_comb begin
    new_entry    = cur;
    move         = 1'b0;
    upd          = 1'b0;
    res_slot_nxt = '0;
    res_hit_nxt  = 1'b0;
    res_nr_nxt   = 1'b0;
    res_st_nxt   = ST_OK;
    case (func_r)
      FN_GET: begin
        if (hitsel_r) begin
          res_slot_nxt = SLOT_FIELD_W'(cur.slot_id);
          res_hit_nxt  = 1'b1;
          res_nr_nxt   = !cur.valid;
          if (cur.cnt == COUNT_MAX) begin
            res_st_nxt = ST_OVERFLOW;
          end else begin
            new_entry.cnt = cur.cnt + CNT_W'(1);
            move          = apply_go;
          end
        end else if (found_r) begin
          new_entry.blk      = req_r.blk;
          new_entry.dev      = req_r.dev;
          new_entry.assigned = 1'b1;
          new_entry.valid    = 1'b0;
          new_entry.cnt      = CNT_W'(1);
          move               = apply_go;
          res_slot_nxt       = SLOT_FIELD_W'(cur.slot_id);
          res_nr_nxt         = 1'b1;
        end else begin
          res_st_nxt = ST_NOFREE;
        end
      end
      FN_REL: begin
        res_slot_nxt = req_r.slot;
        if (found_r && (cur.cnt != '0)) begin
          new_entry.cnt = cur.cnt - CNT_W'(1);
          upd           = apply_go;
        end else begin
          res_st_nxt = ST_UNREF;
        end
      end
      FN_MARK: begin
        res_slot_nxt    = req_r.slot;
        new_entry.valid = 1'b1;
        upd             = apply_go && found_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      res_slot_r <= res_slot_nxt;
      res_hit_r  <= res_hit_nxt;
      res_nr_r   <= res_nr_nxt;
      res_st_r   <= res_st_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_slot = res_slot_r;
  assign out_ch.hit         = res_hit_r;
  assign out_ch.needs_read  = res_nr_r;
  assign out_ch.status      = res_st_r;

endmodule

[hw/rtl/blru_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blru_checker
// Port-level checks of the LRU buffer manager, bound to the top level.
// ----------------------------------------------------------------------------
module blru_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_result_slot,
  input logic       out_hit,
  input logic       out_needs_read,
  input logic [1:0] out_status
);
  import blru_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOFREE) |->
      (out_result_slot == '0) && !out_hit && !out_needs_read)
    else $error("no-free result carries a slot");

  a_unref: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNREF) |-> !out_hit && !out_needs_read)
    else $error("release error flagged as hit");

endmodule

bind block_buffer_lru_manager_core blru_checker u_blru_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_slot (out_ch.result_slot),
  .out_hit         (out_ch.hit),
  .out_needs_read  (out_ch.needs_read),
  .out_status      (out_ch.status)
);
